/* rtl/core/ushm_pkg.sv */
// Shared types and constants for the unsharp mask box filter core.
// Holds register map, reset values and the controller/datapath link structs.
// No dependencies.
`default_nettype none

package ushm_pkg;

  localparam int MaxRadiusDef = 7;
  localparam int MaxWidthDef  = 1024;

  // Row counters carry one spare bit: the input side runs ahead of the last row.
  localparam int RowW      = 13;
  localparam int RadRegW   = 3;
  localparam int IaW       = 16;
  localparam int GainW     = 12;
  localparam int WidthRegW = 11;
  localparam int HeightW   = 12;
  localparam int PaddrW    = 5;
  localparam int PdataW    = 32;

  localparam logic [RadRegW-1:0]   RadiusRst = 3'd1;
  localparam logic [IaW-1:0]       InvAreaRst = 16'd7282;
  localparam logic [GainW-1:0]     GainRst    = 12'd256;
  localparam logic [WidthRegW-1:0] WidthRst   = 11'd640;
  localparam logic [HeightW-1:0]   HeightRst  = 12'd480;

  typedef enum logic [2:0] {
    RegRadius  = 3'd0,
    RegInvArea = 3'd1,
    RegGain    = 3'd2,
    RegWidth   = 3'd3,
    RegHeight  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic cap;
    logic store;
    logic tgt;
    logic p_rd;
    logic p_cap;
    logic w_rd;
    logic w_acc;
    logic blur;
    logic mix1;
    logic mix2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic early;
    logic full_win;
    logic win_last;
    logic out_blocked;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/ushm_regs.sv */
// Configuration registers behind the APB-style port, with clamped geometry.
// Depends on ushm_pkg.
`default_nettype none

module ushm_regs import ushm_pkg::*; #(
  parameter int MAX_RADIUS = MaxRadiusDef,
  parameter int MAX_WIDTH  = MaxWidthDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [PaddrW-1:0]                   paddr,
  input  wire logic [PdataW-1:0]                   pwdata,
  output logic      [PdataW-1:0]                   prdata,
  output logic                                     pready,
  output logic      [$clog2(MAX_RADIUS+1)-1:0]     radius_o,
  output logic      [$clog2(MAX_WIDTH+1)-1:0]      width_o,
  output logic      [HeightW-1:0]                  height_o,
  output logic      [IaW-1:0]                      inv_area_o,
  output logic      [GainW-1:0]                    gain_o
);

  localparam int RdW  = $clog2(MAX_RADIUS + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RxW  = (RdW > RadRegW) ? RdW : RadRegW;
  localparam int WxW  = (WW > WidthRegW) ? WW : WidthRegW;
  localparam int MinW = 2 * MAX_RADIUS + 2;

  logic [RadRegW-1:0]   radius_q;
  logic [IaW-1:0]       inv_area_q;
  logic [GainW-1:0]     gain_q;
  logic [WidthRegW-1:0] width_q;
  logic [HeightW-1:0]   height_q;
  logic                 wr_en;
  reg_idx_e             idx;
  logic [RxW-1:0]       rad_x;
  logic [WxW-1:0]       wid_x;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RadiusRst;
      inv_area_q <= InvAreaRst;
      gain_q     <= GainRst;
      width_q    <= WidthRst;
      height_q   <= HeightRst;
    end else if (wr_en) begin
      case (idx)
        RegRadius:  radius_q   <= pwdata[RadRegW-1:0];
        RegInvArea: inv_area_q <= pwdata[IaW-1:0];
        RegGain:    gain_q     <= pwdata[GainW-1:0];
        RegWidth:   width_q    <= pwdata[WidthRegW-1:0];
        RegHeight:  height_q   <= pwdata[HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegRadius:  prdata = PdataW'(radius_q);
      RegInvArea: prdata = PdataW'(inv_area_q);
      RegGain:    prdata = PdataW'(gain_q);
      RegWidth:   prdata = PdataW'(width_q);
      RegHeight:  prdata = PdataW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // Clamp geometry into the range the line store supports
  always_comb begin
    rad_x = RxW'(radius_q);
    if (rad_x == '0) begin
      radius_o = RdW'(1);
    end else if (rad_x > RxW'(MAX_RADIUS)) begin
      radius_o = RdW'(MAX_RADIUS);
    end else begin
      radius_o = RdW'(rad_x);
    end
    wid_x = WxW'(width_q);
    if (wid_x < WxW'(MinW)) begin
      width_o = WW'(MinW);
    end else if (wid_x > WxW'(MAX_WIDTH)) begin
      width_o = WW'(MAX_WIDTH);
    end else begin
      width_o = WW'(wid_x);
    end
    height_o   = (height_q == '0) ? HeightW'(1) : height_q;
    inv_area_o = inv_area_q;
    gain_o     = gain_q;
  end

endmodule

`default_nettype wire

/* rtl/core/ushm_ctrl.sv */
// Sequencer for one word: store, position check, window sweep, sharpen, issue.
// Depends on ushm_pkg.
`default_nettype none

module ushm_ctrl import ushm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_STORE = 12'b0000_0000_0010,
    S_TGT   = 12'b0000_0000_0100,
    S_CMP   = 12'b0000_0000_1000,
    S_PRD   = 12'b0000_0001_0000,
    S_PCAP  = 12'b0000_0010_0000,
    S_WRD   = 12'b0000_0100_0000,
    S_WACC  = 12'b0000_1000_0000,
    S_BLUR  = 12'b0001_0000_0000,
    S_MIX1  = 12'b0010_0000_0000,
    S_MIX2  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_STORE;
        end
      end
      S_STORE: begin
        // drop a flush word while the frame is still coming in
        if (sts_i.ignore) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.store = 1'b1;
          state_d     = S_TGT;
        end
      end
      S_TGT: begin
        cmd_o.tgt = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        state_d = sts_i.early ? S_IDLE : S_PRD;
      end
      S_PRD: begin
        cmd_o.p_rd = 1'b1;
        state_d    = S_PCAP;
      end
      S_PCAP: begin
        cmd_o.p_cap = 1'b1;
        state_d     = sts_i.full_win ? S_WRD : S_BLUR;
      end
      S_WRD: begin
        cmd_o.w_rd = 1'b1;
        state_d    = S_WACC;
      end
      S_WACC: begin
        cmd_o.w_acc = 1'b1;
        state_d     = sts_i.win_last ? S_BLUR : S_WRD;
      end
      S_BLUR: begin
        cmd_o.blur = 1'b1;
        state_d    = S_MIX1;
      end
      S_MIX1: begin
        cmd_o.mix1 = 1'b1;
        state_d    = S_MIX2;
      end
      S_MIX2: begin
        cmd_o.mix2 = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ushm_dp.sv */
// Datapath: line store, raster counters, window accumulator, sharpen arithmetic.
// Depends on ushm_pkg; driven by ushm_ctrl.
`default_nettype none

module ushm_dp import ushm_pkg::*; #(
  parameter int MAX_RADIUS = MaxRadiusDef,
  parameter int MAX_WIDTH  = MaxWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire cmd_t                            cmd_i,
  output sts_t                                 sts_o,
  input  wire logic [7:0]                      pixel_i,
  input  wire logic                            flush_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [7:0]                      out_pixel_o,
  output logic                                 frame_end_o,
  input  wire logic [$clog2(MAX_RADIUS+1)-1:0] radius_i,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  width_i,
  input  wire logic [HeightW-1:0]              height_i,
  input  wire logic [IaW-1:0]                  inv_area_i,
  input  wire logic [GainW-1:0]                gain_i
);

  localparam int Ring  = 2 * MAX_RADIUS + 1;
  localparam int Depth = Ring * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int RB    = $clog2(Ring);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RdW   = $clog2(MAX_RADIUS + 1);
  localparam int KW    = RdW + 1;
  localparam int PW    = RowW + WW + 1;
  localparam int WsW   = $clog2(Ring * Ring * 255 + 1);
  localparam int PrW   = WsW + IaW;
  localparam int BlW   = WsW + 1;
  localparam int PaW   = GainW + 1 + 8;
  localparam int GbW   = GainW + BlW;
  localparam int XW    = GbW + 2;

  logic [7:0]      mem [Depth];
  logic [7:0]      rdata_q;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;

  logic [7:0]      pix_q;
  logic            flush_q;
  logic [CW-1:0]   in_col_q, out_col_q, win_col_q;
  logic [RowW-1:0] in_row_q, out_row_q;
  logic [RB-1:0]   in_ring_q, out_ring_q, win_ring_q;
  logic [KW-1:0]   win_i_q, win_j_q;
  logic [PW-1:0]   pos_q, tgt_q;
  logic [7:0]      p_q;
  logic [WsW-1:0]  ws_q;
  logic [PrW-1:0]  prod_q;
  logic [BlW-1:0]  blur_q;
  logic [PaW-1:0]  pa_q;
  logic [GbW-1:0]  gb_q;
  logic            out_valid_q;
  logic [7:0]      out_pixel_q;
  logic            frame_end_q;

  logic [KW-1:0]   two_r;
  logic [WW-1:0]   in_col_nx, out_col_nx;
  logic [RowW-1:0] in_row_nx, out_row_nx;
  logic [RB-1:0]   in_ring_nx, out_ring_nx, win_ring_st;
  logic            in_wrap, out_wrap, out_done, in_live;
  logic [XW-1:0]   x_c;
  logic [7:0]      sat_c;

  function automatic logic [AW-1:0] st_addr(input logic [RB-1:0] ring,
                                            input logic [CW-1:0] col);
    return AW'(ring) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  function automatic logic [RB-1:0] ring_inc(input logic [RB-1:0] ring);
    return (ring == RB'(Ring - 1)) ? '0 : ring + RB'(1);
  endfunction

  assign two_r = {radius_i, 1'b0};
  assign in_live = (in_row_q < RowW'(height_i));

  // Line store, one write or one read per cycle
  assign waddr = st_addr(in_ring_q, in_col_q);
  assign raddr = cmd_i.p_rd ? st_addr(out_ring_q, out_col_q) : st_addr(win_ring_q, win_col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && in_live) begin
      mem[waddr] <= pix_q;
    end
    if (cmd_i.p_rd || cmd_i.w_rd) begin
      rdata_q <= mem[raddr];
    end
  end

  // Raster advance for both sides
  always_comb begin
    in_col_nx  = WW'(in_col_q) + WW'(1);
    in_wrap    = (in_col_nx >= width_i);
    in_row_nx  = in_row_q + RowW'(1);
    in_ring_nx = ring_inc(in_ring_q);
    out_col_nx = WW'(out_col_q) + WW'(1);
    out_wrap   = (out_col_nx >= width_i);
    out_row_nx = out_row_q + RowW'(1);
    out_ring_nx = ring_inc(out_ring_q);
    out_done   = (out_wrap ? out_row_nx : out_row_q) >= RowW'(height_i);
    win_ring_st = (out_ring_q >= RB'(radius_i)) ? out_ring_q - RB'(radius_i)
                                                : out_ring_q + RB'(Ring) - RB'(radius_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else if (cmd_i.load_out && out_done) begin
      // frame complete: both sides start over
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else begin
      if (cmd_i.store) begin
        if (in_wrap) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_nx;
          in_ring_q <= in_ring_nx;
        end else begin
          in_col_q  <= CW'(in_col_nx);
        end
      end
      if (cmd_i.load_out) begin
        if (out_wrap) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_nx;
          out_ring_q <= out_ring_nx;
        end else begin
          out_col_q  <= CW'(out_col_nx);
        end
      end
    end
  end

  // Payload pipeline, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      pix_q   <= pixel_i;
      flush_q <= flush_i;
    end
    if (cmd_i.store) begin
      pos_q <= PW'(in_row_q) * PW'(width_i) + PW'(in_col_q);
    end
    if (cmd_i.tgt) begin
      tgt_q <= (PW'(out_row_q) + PW'(radius_i)) * PW'(width_i)
               + PW'(out_col_q) + PW'(radius_i);
    end
    if (cmd_i.p_cap) begin
      p_q        <= rdata_q;
      ws_q       <= '0;
      win_i_q    <= '0;
      win_j_q    <= '0;
      win_ring_q <= win_ring_st;
      win_col_q  <= out_col_q - CW'(radius_i);
    end
    if (cmd_i.w_acc) begin
      ws_q <= ws_q + WsW'(rdata_q);
      if (win_j_q == two_r) begin
        win_j_q    <= '0;
        win_i_q    <= win_i_q + KW'(1);
        win_col_q  <= out_col_q - CW'(radius_i);
        win_ring_q <= ring_inc(win_ring_q);
      end else begin
        win_j_q   <= win_j_q + KW'(1);
        win_col_q <= win_col_q + CW'(1);
      end
    end
    if (cmd_i.blur) begin
      prod_q <= PrW'(ws_q) * PrW'(inv_area_i);
    end
    if (cmd_i.mix1) begin
      blur_q <= BlW'((prod_q + PrW'(32768)) >> 16);
      pa_q   <= (PaW'(gain_i) + PaW'(256)) * PaW'(p_q);
    end
    if (cmd_i.mix2) begin
      gb_q <= GbW'(gain_i) * GbW'(blur_q);
    end
    if (cmd_i.load_out) begin
      out_pixel_q <= sat_c;
      frame_end_q <= out_done;
    end
  end

  // round half up, then clamp into 0..255
  always_comb begin
    x_c = XW'(pa_q) - XW'(gb_q) + XW'(128);
    if (x_c[XW-1]) begin
      sat_c = 8'd0;
    end else if (|x_c[XW-2:16]) begin
      sat_c = 8'd255;
    end else begin
      sat_c = x_c[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign frame_end_o = frame_end_q;

  always_comb begin
    sts_o.ignore      = in_live && flush_q;
    sts_o.early       = (pos_q < tgt_q);
    sts_o.full_win    = (out_row_q >= RowW'(radius_i))
                     && ((out_row_q + RowW'(radius_i)) < RowW'(height_i))
                     && (WW'(out_col_q) >= WW'(radius_i))
                     && ((WW'(out_col_q) + WW'(radius_i)) < width_i);
    sts_o.win_last    = (win_i_q == two_r) && (win_j_q == two_r);
    sts_o.out_blocked = out_valid_q && out_stall_i;
  end

  a_out_rise_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load_out))
    else $error("output word appeared without a load");

  a_win_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.w_acc |-> (win_i_q <= two_r) && (win_j_q <= two_r))
    else $error("window sweep ran past its edge");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.load_out) && out_valid_q && frame_end_q |->
      (out_row_q == '0) && (in_row_q == '0) && (out_col_q == '0))
    else $error("counters not cleared after last word of frame");

endmodule

`default_nettype wire

/* rtl/core/unsharp_mask_box_filter_core.sv */
// Top level of the unsharp mask box filter: registers, sequencer, datapath.
// Depends on ushm_pkg, ushm_regs, ushm_ctrl, ushm_dp.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid_i/in_stall_o | pixel_i, flush_i
//   out     | source    | out_valid_o/out_stall_i | out_pixel_o, frame_end_o
//   cfg     | sink      | psel/penable/pready  | paddr, pwdata, prdata
//
// One word at a time. A dropped flush ends after store, a word with no result
// after the target compare; a result reads its (2*radius+1)^2 window pixels
// in turn over the single line store port if the window is inside the frame.
// Reset clears counters and registers; the line store holds no reset state.
// A stalled result waits in the output register; the block resumes once taken.
`default_nettype none

module unsharp_mask_box_filter_core import ushm_pkg::*; #(
  parameter int MAX_RADIUS = MaxRadiusDef,
  parameter int MAX_WIDTH  = MaxWidthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        pixel_i,
  input  wire logic              flush_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [7:0]        out_pixel_o,
  output logic                   frame_end_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  logic [$clog2(MAX_RADIUS+1)-1:0] radius;
  logic [$clog2(MAX_WIDTH+1)-1:0]  width;
  logic [HeightW-1:0]              height;
  logic [IaW-1:0]                  inv_area;
  logic [GainW-1:0]                gain;
  cmd_t                            cmd;
  sts_t                            sts;

  ushm_regs #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .radius_o  (radius),
    .width_o   (width),
    .height_o  (height),
    .inv_area_o(inv_area),
    .gain_o    (gain)
  );

  ushm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ushm_dp #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .pixel_i    (pixel_i),
    .flush_i    (flush_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_pixel_o(out_pixel_o),
    .frame_end_o(frame_end_o),
    .radius_i   (radius),
    .width_i    (width),
    .height_i   (height),
    .inv_area_i (inv_area),
    .gain_i     (gain)
  );

endmodule

`default_nettype wire
